[rtl/mfb_pkg.sv]
// Shared constants, action and register codes, and types for the monochrome
// framebuffer text renderer. No deps; imported by all rtl but the frame RAM.
package mfb_pkg;

	// Panel geometry, page layout: one byte holds eight rows of one column
	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int FRAME_PAGES    = (DISPLAY_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES    = DISPLAY_WIDTH * FRAME_PAGES;
	localparam int ADDR_W         = $clog2(FRAME_BYTES);

	// Field widths
	localparam int ACTION_W   = 3;
	localparam int COORD_W    = 8;
	localparam int SPAN_W     = COORD_W + 1;
	localparam int ROW_BITS_W = 16;
	localparam int ROW_IDX_W  = 5;
	localparam int ADDR_IN_W  = 10;
	localparam int FONT_W_W   = 5;
	localparam int FONT_H_W   = 6;
	localparam int BYTE_W     = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 2'd1;
	localparam logic [FONT_W_W-1:0]  FONT_WIDTH_RST  = 5'd7;
	localparam logic [FONT_H_W-1:0]  FONT_HEIGHT_RST = 6'd10;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_SET_CURSOR = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PIXEL      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_FILL       = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_GLYPH_ROW  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;

	// Single set bit in the leftmost glyph column; full byte for a lit fill
	localparam logic [ROW_BITS_W-1:0] ROW_MSB   = 16'h8000;
	localparam logic [BYTE_W-1:0]     BYTE_ONES = 8'hFF;

	// Pixel unit result: target byte, its merged value, and bounds check
	typedef struct packed {
		logic              in_range;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] merged;
	} pix_res_t;

endpackage

[rtl/mfb_frame_ram.sv]
// Framebuffer byte store: one write port, one read port with registered data.
// Generic; no package dependency.
module mfb_frame_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/mfb_pixel_unit.sv]
// Shared pixel unit: bounds check, page-layout byte address, bit merge.
// Depends on mfb_pkg.
module mfb_pixel_unit (
	input  logic [mfb_pkg::COORD_W-1:0] x,
	input  logic [mfb_pkg::COORD_W-1:0] y,
	input  logic                        lit,
	input  logic [mfb_pkg::BYTE_W-1:0]  old_byte,
	output mfb_pkg::pix_res_t           res
);
	import mfb_pkg::*;

	logic [BYTE_W-1:0] mask;

	// Address is column plus page times width; bit is row mod 8
	always_comb begin
		mask         = BYTE_W'(1) << y[2:0];
		res.in_range = (int'(x) < DISPLAY_WIDTH) && (int'(y) < DISPLAY_HEIGHT);
		res.addr     = ADDR_W'(int'(x) + int'(y[COORD_W-1:3]) * DISPLAY_WIDTH);
		res.merged   = lit ? (old_byte | mask) : (old_byte & ~mask);
	end

endmodule

[rtl/mono_framebuffer_text_renderer.sv]
// Each accepted item goes from idle to an execute state, then per action: set cursor,
// refused or unknown action go straight to the result state; draw pixel reads and then
// merges its byte; read byte fetches it; glyph row reads and merges each column in turn
// through the single frame RAM port pair; fill sweeps every byte of the frame store.
// One item is in flight at a time: in_ready is high only while the sequencer is idle.
// Reset: cursor 0, font 7x10, then a clearing pass over all FRAME_BYTES (1024) bytes
// writes zero to the frame store; no item is accepted until it ends.
module mono_framebuffer_text_renderer (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfb_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mfb_pkg::ACTION_W-1:0]   action,
	input  logic [mfb_pkg::COORD_W-1:0]    x,
	input  logic [mfb_pkg::COORD_W-1:0]    y,
	input  logic                          color,
	input  logic [mfb_pkg::ROW_BITS_W-1:0] row_bits,
	input  logic [mfb_pkg::ROW_IDX_W-1:0]  row_index,
	input  logic [mfb_pkg::ADDR_IN_W-1:0]  address,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [mfb_pkg::BYTE_W-1:0]     read_data
);
	import mfb_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_MERGE,
		S_FETCH,
		S_RESULT
	} state_t;

	state_t                state_q;
	logic [FONT_W_W-1:0]   font_width_q;
	logic [FONT_H_W-1:0]   font_height_q;
	logic [COORD_W-1:0]    cursor_col_q;
	logic [COORD_W-1:0]    cursor_row_q;
	logic [ACTION_W-1:0]   action_q;
	logic                  color_q;
	logic [ROW_BITS_W-1:0] bits_q;
	logic [ROW_IDX_W-1:0]  row_index_q;
	logic [ADDR_IN_W-1:0]  address_q;
	logic [COORD_W-1:0]    px_x_q;
	logic [COORD_W-1:0]    px_y_q;
	logic [FONT_W_W-1:0]   col_q;
	logic [ADDR_W-1:0]     sweep_cnt_q;
	logic [BYTE_W-1:0]     fill_q;
	logic                  sweep_reply_q;
	logic                  res_ok_q;
	logic [BYTE_W-1:0]     res_data_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [BYTE_W-1:0]     read_data_q;

	logic                  lit;
	logic                  glyph_refuse;
	logic                  glyph_last_row;
	logic                  glyph_last_col;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [BYTE_W-1:0]     ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;
	pix_res_t              pix;

	// Shared pixel unit and frame store
	mfb_pixel_unit u_pixel (
		.x        (px_x_q),
		.y        (px_y_q),
		.lit      (lit),
		.old_byte (ram_rdata),
		.res      (pix)
	);

	mfb_frame_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Set bits draw ink, clear bits its inverse; a lone pixel carries ROW_MSB
	assign lit = bits_q[ROW_BITS_W-1] ? color_q : ~color_q;

	// Glyph bounds and row/column end checks
	always_comb begin
		glyph_refuse =
			(({1'b0, cursor_col_q} + SPAN_W'(font_width_q)) >= SPAN_W'(DISPLAY_WIDTH)) ||
			(({1'b0, cursor_row_q} + SPAN_W'(font_height_q)) >= SPAN_W'(DISPLAY_HEIGHT)) ||
			({1'b0, row_index_q} >= font_height_q);
		glyph_last_row = (({1'b0, row_index_q} + FONT_H_W'(1)) == font_height_q);
		glyph_last_col = ((col_q + FONT_W_W'(1)) == font_width_q);
	end

	// Frame store port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pix.addr;
		ram_wdata = pix.merged;
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_cnt_q;
			ram_wdata = fill_q;
		end else if (state_q == S_MERGE) begin
			ram_we = 1'b1;
		end
		ram_raddr = (action_q == ACT_READ) ? ADDR_W'(address_q) : pix.addr;
	end

	// Sequencer, configuration registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			font_width_q  <= FONT_WIDTH_RST;
			font_height_q <= FONT_HEIGHT_RST;
			cursor_col_q  <= '0;
			cursor_row_q  <= '0;
			action_q      <= ACT_SET_CURSOR;
			sweep_cnt_q   <= '0;
			fill_q        <= '0;
			sweep_reply_q <= 1'b0;
			col_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// Configuration writes; indexes past the list are dropped
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FONT_WIDTH:  font_width_q  <= cfg_data[FONT_W_W-1:0];
					CFG_FONT_HEIGHT: font_height_q <= cfg_data[FONT_H_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
					if (sweep_cnt_q == ADDR_W'(FRAME_BYTES - 1)) begin
						sweep_cnt_q <= '0;
						res_ok_q    <= 1'b1;
						res_data_q  <= '0;
						state_q     <= sweep_reply_q ? S_RESULT : S_IDLE;
					end
				end

				S_IDLE: begin
					if (in_valid) begin
						action_q    <= action;
						color_q     <= color;
						row_index_q <= row_index;
						address_q   <= address;
						col_q       <= '0;
						if (action == ACT_GLYPH_ROW) begin
							px_x_q <= cursor_col_q;
							px_y_q <= COORD_W'(cursor_row_q + COORD_W'(row_index));
							bits_q <= row_bits;
						end else begin
							px_x_q <= x;
							px_y_q <= y;
							bits_q <= ROW_MSB;
						end
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					res_ok_q   <= 1'b0;
					res_data_q <= '0;
					state_q    <= S_RESULT;
					case (action_q)
						ACT_SET_CURSOR: begin
							cursor_col_q <= px_x_q;
							cursor_row_q <= px_y_q;
							res_ok_q     <= 1'b1;
						end
						ACT_PIXEL: begin
							if (pix.in_range) begin
								state_q <= S_READ;
							end
						end
						ACT_FILL: begin
							fill_q        <= color_q ? BYTE_ONES : '0;
							sweep_reply_q <= 1'b1;
							sweep_cnt_q   <= '0;
							state_q       <= S_SWEEP;
						end
						ACT_GLYPH_ROW: begin
							if (!glyph_refuse) begin
								if (font_width_q == '0) begin
									res_ok_q <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
						end
						ACT_READ: begin
							if (int'(address_q) < FRAME_BYTES) begin
								state_q <= S_FETCH;
							end
						end
						default: ;
					endcase
				end

				// Read issued at the pixel address; merge lands next cycle
				S_READ: begin
					state_q <= S_MERGE;
				end

				S_MERGE: begin
					if (action_q == ACT_GLYPH_ROW && !glyph_last_col) begin
						col_q   <= col_q + FONT_W_W'(1);
						px_x_q  <= px_x_q + COORD_W'(1);
						bits_q  <= {bits_q[ROW_BITS_W-2:0], 1'b0};
						state_q <= S_READ;
					end else begin
						if (action_q == ACT_GLYPH_ROW && glyph_last_row) begin
							cursor_col_q <= cursor_col_q + COORD_W'(font_width_q);
						end
						res_ok_q <= 1'b1;
						state_q  <= S_RESULT;
					end
				end

				S_FETCH: begin
					res_ok_q   <= 1'b1;
					res_data_q <= ram_rdata;
					state_q    <= S_RESULT;
				end

				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						ok_q          <= res_ok_q;
						read_data_q   <= res_data_q;
						sweep_reply_q <= 1'b0;
						state_q       <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign read_data = read_data_q;

	// A merge write always targets an on-screen pixel
	a_merge_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> pix.in_range)
		else $error("merge write to an off-screen pixel");

	// The cursor moves only on set cursor or at the end of a glyph row
	a_cursor_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cursor_col_q) |-> ($past(state_q == S_EXEC) || $past(state_q == S_MERGE)))
		else $error("cursor column changed outside set cursor or glyph end");

	// A result appears only from the result state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result valid raised outside the result state");

endmodule

[tb/tb_mono_framebuffer_text_renderer.sv]
// Testbench for mono_framebuffer_text_renderer: a scoreboard class keeps its own frame
// store, cursor and font, predicts each action's reply and checks the replies in order.
// Depends on rtl/mfb_pkg.sv and rtl/mono_framebuffer_text_renderer.sv.
module tb_mono_framebuffer_text_renderer;
	import mfb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int RANDOM_ITEMS  = 650;
	localparam int MAX_FILLS     = 6;
	localparam int ACT_LAST_CODE = (1 << ACTION_W) - 1;
	localparam int N_FIXED       = 8;
	localparam int N_PHASES      = 13;

	typedef struct packed {
		logic [ACTION_W-1:0]   act;
		logic [COORD_W-1:0]    px;
		logic [COORD_W-1:0]    py;
		logic                  ink;
		logic [ROW_BITS_W-1:0] bits;
		logic [ROW_IDX_W-1:0]  idx;
		logic [ADDR_IN_W-1:0]  addr;
	} fb_item_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

	// Shadow framebuffer and the queue of replies it predicts
	class fb_scoreboard;
		logic [BYTE_W-1:0]   frame [FRAME_BYTES];
		logic [COORD_W-1:0]  cur_col;
		logic [COORD_W-1:0]  cur_row;
		logic [FONT_W_W-1:0] glyph_w;
		logic [FONT_H_W-1:0] glyph_h;
		logic                exp_ok_q [$];
		logic [BYTE_W-1:0]   exp_data_q [$];
		int                  replies;
		int                  errors;

		function new();
			foreach (frame[i]) frame[i] = '0;
			cur_col = '0;
			cur_row = '0;
			glyph_w = FONT_WIDTH_RST;
			glyph_h = FONT_HEIGHT_RST;
			replies = 0;
			errors  = 0;
		endfunction

		function int pending();
			return exp_ok_q.size();
		endfunction

		task report(string what, int got, int want);
			$display("[%0t] reply %0d: %s is %0h, predicted %0h", $time, replies, what, got,
				want);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_FONT_WIDTH)
				glyph_w = data[FONT_W_W-1:0];
			else if (idx == CFG_FONT_HEIGHT)
				glyph_h = data[FONT_H_W-1:0];
		endfunction

		// One pixel in page layout; off-screen leaves the store alone
		function bit plot(int px, int py, logic lit);
			int a;
			logic [BYTE_W-1:0] mask;
			if (px >= DISPLAY_WIDTH || py >= DISPLAY_HEIGHT)
				return 1'b0;
			a = px + (py / 8) * DISPLAY_WIDTH;
			mask = 8'h01 << (py % 8);
			if (lit)
				frame[a] = frame[a] | mask;
			else
				frame[a] = frame[a] & ~mask;
			return 1'b1;
		endfunction

		// One glyph row at the cursor, MSB is the leftmost column
		function bit draw_row(logic [ROW_BITS_W-1:0] bits, int ri, logic ink);
			int j;
			logic lit;
			if (int'(cur_col) + int'(glyph_w) >= DISPLAY_WIDTH ||
			    int'(cur_row) + int'(glyph_h) >= DISPLAY_HEIGHT)
				return 1'b0;
			if (ri >= int'(glyph_h))
				return 1'b0;
			for (j = 0; j < int'(glyph_w); j++) begin
				// columns past the row bits draw as clear bits
				lit = (j < ROW_BITS_W) ? bits[ROW_BITS_W-1-j] : 1'b0;
				void'(plot(int'(cur_col) + j, int'(cur_row) + ri, lit ? ink : ~ink));
			end
			if (ri + 1 == int'(glyph_h))
				cur_col = cur_col + COORD_W'(glyph_w);
			return 1'b1;
		endfunction

		function void accept_action(fb_item_t it);
			logic              rok;
			logic [BYTE_W-1:0] rdata;
			rok   = 1'b0;
			rdata = '0;
			case (it.act)
				ACT_SET_CURSOR: begin
					cur_col = it.px;
					cur_row = it.py;
					rok = 1'b1;
				end
				ACT_PIXEL: rok = plot(int'(it.px), int'(it.py), it.ink);
				ACT_FILL: begin
					foreach (frame[i]) frame[i] = it.ink ? BYTE_ONES : '0;
					rok = 1'b1;
				end
				ACT_GLYPH_ROW: rok = draw_row(it.bits, int'(it.idx), it.ink);
				ACT_READ: begin
					if (int'(it.addr) < FRAME_BYTES) begin
						rdata = frame[it.addr];
						rok = 1'b1;
					end
				end
				default: ;
			endcase
			exp_ok_q.push_back(rok);
			exp_data_q.push_back(rdata);
		endfunction

		task check_reply(logic got_ok, logic [BYTE_W-1:0] got_data);
			logic              want_ok;
			logic [BYTE_W-1:0] want_data;
			if (exp_ok_q.size() == 0) begin
				report("reply with nothing pending, ok", int'(got_ok), 0);
				return;
			end
			want_ok   = exp_ok_q.pop_front();
			want_data = exp_data_q.pop_front();
			if (got_ok !== want_ok)
				report("ok", int'(got_ok), int'(want_ok));
			if (got_data !== want_data)
				report("read_data", int'(got_data), int'(want_data));
			replies++;
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [ACTION_W-1:0]   action    = '0;
	logic [COORD_W-1:0]    x         = '0;
	logic [COORD_W-1:0]    y         = '0;
	logic                  color     = 1'b0;
	logic [ROW_BITS_W-1:0] row_bits  = '0;
	logic [ROW_IDX_W-1:0]  row_index = '0;
	logic [ADDR_IN_W-1:0]  address   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  ok;
	logic [BYTE_W-1:0]     read_data;

	fb_scoreboard sb;

	int       cycle_count = 0;
	rx_mode_t rx_mode     = RX_OPEN;
	int       rx_left     = 0;
	int       rx_hold     = 0;
	int       burst_left  = 1;
	bit       tx_high     = 1'b0;
	int       sent_count  = 0;
	int       fills_done  = 0;
	int       font_w_tb   = int'(FONT_WIDTH_RST);
	int       font_h_tb   = int'(FONT_HEIGHT_RST);
	int       glyph_col   = 0;
	int       glyph_row   = 0;

	// Fixed font settings: wide, zero width, zero height, smallest, largest,
	// width with the unused data bit set, widest, all data bits set
	logic [CFG_DATA_W-1:0] sched_w [N_FIXED] =
		'{6'd20, 6'd0, 6'd9, 6'd1, 6'd16, 6'd37, 6'd31, 6'd63};
	logic [CFG_DATA_W-1:0] sched_h [N_FIXED] =
		'{6'd3, 6'd4, 6'd0, 6'd1, 6'd32, 6'd8, 6'd2, 6'd63};

	mono_framebuffer_text_renderer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.x         (x),
		.y         (y),
		.color     (color),
		.row_bits  (row_bits),
		.row_index (row_index),
		.address   (address),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.read_data (read_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Cycle count and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: picks a new stall mode whenever its random countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= (cycle_count % 4 == 0);
			default: begin
				if (rx_hold > 0) begin
					out_ready <= 1'b0;
					rx_hold <= rx_hold - 1;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 2) == 0)
						rx_hold <= $urandom_range(4, 24);
				end
			end
		endcase
	end

	// Handshake monitor: older reply is checked before a new item is noted
	always @(posedge clk) begin : handshake_monitor
		fb_item_t seen;
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_reply(ok, read_data);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				seen.act  = action;
				seen.px   = x;
				seen.py   = y;
				seen.ink  = color;
				seen.bits = row_bits;
				seen.idx  = row_index;
				seen.addr = address;
				sb.accept_action(seen);
			end
		end
	end

	function automatic fb_item_t noise_item();
		fb_item_t it;
		it.act  = ACTION_W'($urandom_range(0, ACT_LAST_CODE));
		it.px   = COORD_W'($urandom);
		it.py   = COORD_W'($urandom);
		it.ink  = 1'($urandom);
		it.bits = ROW_BITS_W'($urandom);
		it.idx  = ROW_IDX_W'($urandom);
		it.addr = ADDR_IN_W'($urandom);
		return it;
	endfunction

	// Byte in or next to the last glyph cell
	function automatic int near_addr();
		int a;
		a = glyph_col + $urandom_range(0, font_w_tb) +
			((glyph_row + $urandom_range(0, 8)) / 8) * DISPLAY_WIDTH;
		return a % FRAME_BYTES;
	endfunction

	// Sender: valid stays up within a burst, drops for a random gap after it
	task automatic send_item(fb_item_t it);
		int gap;
		action    <= it.act;
		x         <= it.px;
		y         <= it.py;
		color     <= it.ink;
		row_bits  <= it.bits;
		row_index <= it.idx;
		address   <= it.addr;
		in_valid  <= 1'b1;
		tx_high = 1'b1;
		do @(posedge clk); while (!in_ready);
		sent_count++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			tx_high = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic send_cursor(int cx, int cy);
		fb_item_t it;
		it = noise_item();
		it.act = ACT_SET_CURSOR;
		it.px  = COORD_W'(cx);
		it.py  = COORD_W'(cy);
		glyph_col = cx;
		glyph_row = cy;
		send_item(it);
	endtask

	task automatic send_pixel(int px, int py, logic lit);
		fb_item_t it;
		it = noise_item();
		it.act = ACT_PIXEL;
		it.px  = COORD_W'(px);
		it.py  = COORD_W'(py);
		it.ink = lit;
		send_item(it);
	endtask

	task automatic send_glyph(logic [ROW_BITS_W-1:0] bits, int ri, logic ink);
		fb_item_t it;
		it = noise_item();
		it.act  = ACT_GLYPH_ROW;
		it.bits = bits;
		it.idx  = ROW_IDX_W'(ri);
		it.ink  = ink;
		send_item(it);
	endtask

	task automatic send_read(int a);
		fb_item_t it;
		it = noise_item();
		it.act  = ACT_READ;
		it.addr = ADDR_IN_W'(a);
		send_item(it);
	endtask

	task automatic send_fill(logic lit);
		fb_item_t it;
		it = noise_item();
		it.act = ACT_FILL;
		it.ink = lit;
		send_item(it);
	endtask

	task automatic send_unknown(int code);
		fb_item_t it;
		it = noise_item();
		it.act = ACTION_W'(code);
		send_item(it);
	endtask

	// Wait until every reply is in and the block has settled
	task automatic idle_wait();
		if (tx_high) begin
			in_valid <= 1'b0;
			tx_high = 1'b0;
		end
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_font(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
		idle_wait();
		cfg_index <= CFG_FONT_WIDTH;
		cfg_data  <= wdata;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_FONT_HEIGHT;
		cfg_data  <= hdata;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		font_w_tb = int'(wdata[FONT_W_W-1:0]);
		font_h_tb = int'(hdata[FONT_H_W-1:0]);
		@(posedge clk);
	endtask

	// Whole glyph: optional cursor move, rows in order with an occasional stray index, then a few readbacks
	task automatic glyph_episode();
		int               n;
		int               i;
		int               ri;
		logic             ink;
		logic [ROW_BITS_W-1:0] bits;
		ink = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7)
			send_cursor($urandom_range(0, DISPLAY_WIDTH - 1 - font_w_tb),
				$urandom_range(0, DISPLAY_HEIGHT - 1 - font_h_tb));
		n = (font_h_tb > 32) ? 32 : font_h_tb;
		if (n == 0)
			n = 2;
		for (i = 0; i < n; i++) begin
			ri = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : i;
			case ($urandom_range(0, 7))
				0: bits = '0;
				1: bits = '1;
				default: bits = ROW_BITS_W'($urandom);
			endcase
			send_glyph(bits, ri, ink);
			if ($urandom_range(0, 7) == 0)
				send_read(near_addr());
		end
		repeat ($urandom_range(1, 3)) send_read(near_addr());
	endtask

	task automatic random_phase(int quota);
		int       r;
		int       px;
		int       py;
		fb_item_t it;
		while (sent_count < quota) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				glyph_episode();
			end else if (r < 63) begin
				if ($urandom_range(0, 3) != 0) begin
					px = $urandom_range(0, DISPLAY_WIDTH - 1);
					py = $urandom_range(0, DISPLAY_HEIGHT - 1);
				end else begin
					px = $urandom_range(0, 255);
					py = $urandom_range(0, 255);
				end
				send_pixel(px, py, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 1) == 0)
					send_read((px + (py / 8) * DISPLAY_WIDTH) % FRAME_BYTES);
			end else if (r < 83) begin
				if ($urandom_range(0, 1) == 0)
					send_read($urandom_range(0, FRAME_BYTES - 1));
				else
					send_read(near_addr());
			end else if (r < 90) begin
				send_cursor($urandom_range(0, 255), $urandom_range(0, 255));
			end else if (r < 95) begin
				it = noise_item();
				it.act = ACT_GLYPH_ROW;
				send_item(it);
			end else if (r < 98 || fills_done >= MAX_FILLS) begin
				send_unknown($urandom_range(ACT_READ + 1, ACT_LAST_CODE));
			end else begin
				send_fill(1'($urandom_range(0, 1)));
				fills_done++;
			end
		end
	endtask

	initial begin
		int ph;
		int base;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, off-screen pixels, glyph at both edges,
		// row index past the glyph, unknown actions, fills
		send_read(0);
		send_read(FRAME_BYTES - 1);
		send_pixel(0, 0, 1'b1);
		send_pixel(DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 1'b1);
		send_pixel(DISPLAY_WIDTH, 0, 1'b1);
		send_pixel(0, DISPLAY_HEIGHT, 1'b1);
		send_pixel(255, 255, 1'b0);
		send_read(FRAME_BYTES - 1);
		send_cursor(120, 53);
		send_glyph('1, 0, 1'b1);
		send_glyph('0, 31, 1'b0);
		send_glyph(ROW_MSB, 9, 1'b0);
		send_glyph(16'hA5A5, 0, 1'b1);
		send_read(120 + 6 * DISPLAY_WIDTH);
		send_cursor(0, 54);
		send_glyph(16'h1234, 0, 1'b1);
		send_unknown(ACT_READ + 1);
		send_unknown(ACT_READ + 2);
		send_unknown(ACT_LAST_CODE);
		send_fill(1'b1);
		send_read(512);
		send_fill(1'b0);
		send_read(FRAME_BYTES - 1);
		send_cursor(255, 255);
		send_pixel(5, 5, 1'b0);

		// Random phases, each under its own font setting
		base = sent_count;
		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph < N_FIXED)
				set_font(sched_w[ph], sched_h[ph]);
			else if (ph == N_PHASES - 1)
				set_font(CFG_DATA_W'(FONT_WIDTH_RST), CFG_DATA_W'(FONT_HEIGHT_RST));
			else
				set_font(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(1, 32)));
			random_phase(base + (ph + 1) * (RANDOM_ITEMS / N_PHASES));
		end

		idle_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
rtl/mfb_pkg.sv
rtl/mfb_frame_ram.sv
rtl/mfb_pixel_unit.sv
rtl/mono_framebuffer_text_renderer.sv
tb/tb_mono_framebuffer_text_renderer.sv
